// ----- hw/rtl/rmca_pkg.sv -----
// shared types, codes and constants for the rotation matrix compose/apply block
// no dependencies; imported by every module of the block
`default_nettype none

package rmca_pkg;

   localparam int ELEMS       = 9;
   localparam int MAX_RESULTS = 16;

   // multiplier operand and product widths
   localparam int OPW   = 34;
   localparam int PRODW = 64;

   // item modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ROTATE = 2'd1;
   localparam logic [1:0] MODE_POINT  = 2'd2;

   // rotation axes, anything else is z
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   // configuration register indexes
   localparam logic CSR_PAIRED = 1'b0;
   localparam logic CSR_COUNT  = 1'b1;

   // quarter sine polynomial coefficients, q30
   localparam logic signed [OPW-1:0] K1 = 34'sd1686629713;
   localparam logic signed [OPW-1:0] K3 = 34'sd693598668;
   localparam logic signed [OPW-1:0] K5 = 34'sd85569306;
   localparam logic signed [OPW-1:0] K7 = 34'sd5026997;
   localparam logic signed [OPW-1:0] K9 = 34'sd172273;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TRIG,
      ST_ROT,
      ST_APPLY
   } state_type;

   typedef enum logic [2:0] {
      MA_ARG,
      MA_POLY,
      MA_EA,
      MA_EB,
      MA_PX,
      MA_PY,
      MA_PZ
   } mula_type;

   typedef enum logic [2:0] {
      MB_ARG,
      MB_X2,
      MB_COS,
      MB_SIN,
      MB_NSIN,
      MB_RDATA
   } mulb_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      WS_ZERO,
      WS_REQ,
      WS_MIX
   } wsel_type;

   typedef struct packed {
      logic       capture;
      logic       mem_we;
      wsel_type   wsel;
      mula_type   mul_a;
      mulb_type   mul_b;
      acc_op_type acc_op;
      logic       ea_load;
      logic       eb_load;
      logic       arg_load;
      logic       trig_cos;
      logic       x2_load;
      logic       poly_init;
      logic       poly_step;
      logic [2:0] coef_idx;
      logic       trig_load;
      logic       out_load;
      logic [1:0] out_row;
   } cmd_type;

   typedef struct packed {
      logic       paired;
      logic [4:0] count;
   } cfg_type;

   // constant added after each horner step
   function automatic logic signed [OPW-1:0] poly_coef(input logic [2:0] idx);
      logic signed [OPW-1:0] k;
      case (idx)
         3'd0:    k = -K7;
         3'd1:    k = K5;
         3'd2:    k = -K3;
         3'd3:    k = K1;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rmca_datapath.sv -----
// datapath: matrix store, shared multiplier and accumulator, trig and output registers
// depends on rmca_pkg; driven by rmca_ctrl commands
`default_nettype none

module rmca_datapath import rmca_pkg::*; #(
   parameter int NUM_MATRICES = 16,
   parameter int ANGLE_BITS   = 16,
   localparam int DEPTH = NUM_MATRICES * ELEMS,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire cmd_type             cmd,
   input  wire logic [AW-1:0]       mem_waddr,
   input  wire logic [AW-1:0]       mem_raddr,
   input  wire logic signed [17:0]  req_elem_value,
   input  wire logic [15:0]         req_angle,
   input  wire logic signed [31:0]  req_px,
   input  wire logic signed [31:0]  req_py,
   input  wire logic signed [31:0]  req_pz,
   output logic signed [31:0]       out_x,
   output logic signed [31:0]       out_y,
   output logic signed [31:0]       out_z
);

   localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
   localparam logic signed [OPW-1:0] ONE_Q30 = 34'sh040000000;

   logic [17:0]              mem [DEPTH];
   logic [17:0]              rdata_ff;
   logic [17:0]              wdata;

   logic [15:0]              angle_ff;
   logic signed [31:0]       px_ff, py_ff, pz_ff;
   logic signed [OPW-1:0]    arg_ff, x2_ff, poly_ff;
   logic signed [17:0]       sin_ff, cos_ff, ea_ff, eb_ff;
   logic signed [PRODW-1:0]  prod_ff, acc_ff;
   logic signed [31:0]       ox_ff, oy_ff, oz_ff;

   logic [31:0]              turn;
   logic                     flip, neg;
   logic signed [OPW-1:0]    arg_in, a_val, b_val, shifted;
   logic signed [2*OPW-1:0]  full;
   logic signed [OPW-1:0]    p_rnd;
   logic signed [17:0]       mag, trig_val;
   logic signed [PRODW-1:0]  acc_rnd;
   logic signed [17:0]       elem_mix;
   logic signed [31:0]       coord;

   // angle scaled to a 32-bit turn
   assign turn = (({16'b0, angle_ff} & AMASK) << (32 - ANGLE_BITS));
   assign flip = turn[30] ^ cmd.trig_cos;
   assign neg  = cmd.trig_cos ? (turn[31] ^ turn[30]) : turn[31];
   assign arg_in = flip ? (ONE_Q30 - OPW'(turn[29:0])) : OPW'(turn[29:0]);

   always_comb begin
      case (cmd.mul_a)
         MA_ARG:  a_val = arg_ff;
         MA_POLY: a_val = poly_ff;
         MA_EA:   a_val = OPW'(ea_ff);
         MA_EB:   a_val = OPW'(eb_ff);
         MA_PX:   a_val = OPW'(px_ff);
         MA_PY:   a_val = OPW'(py_ff);
         MA_PZ:   a_val = OPW'(pz_ff);
         default: a_val = '0;
      endcase
      case (cmd.mul_b)
         MB_ARG:   b_val = arg_ff;
         MB_X2:    b_val = x2_ff;
         MB_COS:   b_val = OPW'(cos_ff);
         MB_SIN:   b_val = OPW'(sin_ff);
         MB_NSIN:  b_val = -OPW'(sin_ff);
         MB_RDATA: b_val = OPW'($signed(rdata_ff));
         default:  b_val = '0;
      endcase
   end

   assign full    = a_val * b_val;
   assign shifted = OPW'(prod_ff >>> 30);

   // quarter wave rounded to q1.16 and limited
   always_comb begin
      p_rnd = (poly_ff + 34'sd8192) >>> 14;
      if (p_rnd < 34'sd0) begin
         mag = '0;
      end else if (p_rnd > 34'sd65536) begin
         mag = 18'sd65536;
      end else begin
         mag = p_rnd[17:0];
      end
      trig_val = neg ? -mag : mag;
   end

   always_comb begin
      acc_rnd = (acc_ff + 64'sd32768) >>> 16;
      if (acc_rnd > 64'sd131071) begin
         elem_mix = 18'sh1FFFF;
      end else if (acc_rnd < -64'sd131072) begin
         elem_mix = 18'sh20000;
      end else begin
         elem_mix = acc_rnd[17:0];
      end
      if (acc_rnd > 64'sd2147483647) begin
         coord = 32'sh7FFFFFFF;
      end else if (acc_rnd < -64'sd2147483648) begin
         coord = 32'sh80000000;
      end else begin
         coord = acc_rnd[31:0];
      end
   end

   always_comb begin
      case (cmd.wsel)
         WS_REQ:  wdata = req_elem_value;
         WS_MIX:  wdata = elem_mix;
         default: wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[mem_waddr] <= wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= full[PRODW-1:0];
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= prod_ff;
         ACC_ADD:  acc_ff <= acc_ff + prod_ff;
         default:  acc_ff <= acc_ff;
      endcase
      if (cmd.capture) begin
         angle_ff <= req_angle;
         px_ff    <= req_px;
         py_ff    <= req_py;
         pz_ff    <= req_pz;
      end
      if (cmd.arg_load) arg_ff <= arg_in;
      if (cmd.x2_load) x2_ff <= shifted;
      if (cmd.poly_init) begin
         poly_ff <= K9;
      end else if (cmd.poly_step) begin
         poly_ff <= shifted + poly_coef(cmd.coef_idx);
      end
      if (cmd.trig_load) begin
         if (cmd.trig_cos) cos_ff <= trig_val;
         else sin_ff <= trig_val;
      end
      if (cmd.ea_load) ea_ff <= $signed(rdata_ff);
      if (cmd.eb_load) eb_ff <= $signed(rdata_ff);
      if (cmd.out_load) begin
         case (cmd.out_row)
            2'd0:    ox_ff <= coord;
            2'd1:    oy_ff <= coord;
            default: oz_ff <= coord;
         endcase
      end
   end

   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rmca_ctrl.sv -----
// controller: item decode, store clearing, trig, rotation and point sequencing
// depends on rmca_pkg; commands rmca_datapath
`default_nettype none

module rmca_ctrl import rmca_pkg::*; #(
   parameter int NUM_MATRICES = 16,
   localparam int DEPTH = NUM_MATRICES * ELEMS,
   localparam int AW    = $clog2(DEPTH),
   localparam int LIMIT = (NUM_MATRICES < MAX_RESULTS) ? NUM_MATRICES : MAX_RESULTS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    req_mode,
   input  wire logic [3:0]    req_matrix_index,
   input  wire logic [3:0]    req_elem_index,
   input  wire logic [1:0]    req_axis,
   input  wire cfg_type       cfg,
   output cmd_type            cmd,
   output logic [AW-1:0]      mem_waddr,
   output logic [AW-1:0]      mem_raddr,
   output logic               busy,
   output logic               rsp_valid,
   output logic [3:0]         rsp_used_matrix,
   output logic               rsp_last_result
);

   state_type     state_ff, state_in;
   logic [3:0]    step_ff, step_in;
   logic [1:0]    sub_ff, sub_in;
   logic [3:0]    mat_ff, mat_in;
   logic [3:0]    lastk_ff, lastk_in;
   logic          single_ff, single_in;
   logic [1:0]    axis_ff, axis_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    used_ff, used_in;
   logic          last_ff, last_in;

   logic          mi_ok, is_last;
   logic [AW-1:0] mi_base;
   logic [4:0]    cnt_n;
   logic [3:0]    cnt_last;
   logic [1:0]    pos_i, pos_j;
   logic [3:0]    col_off, row_off;
   logic [AW-1:0] addr_a, addr_b;
   mulb_type      s_op, ns_op;

   assign mi_ok   = 32'(req_matrix_index) < NUM_MATRICES;
   assign mi_base = AW'({req_matrix_index, 3'b000}) + AW'(req_matrix_index);
   assign cnt_n   = (cfg.count == 5'd0) ? 5'd1 : cfg.count;
   assign cnt_last = (32'(cnt_n) > LIMIT) ? 4'(LIMIT - 1) : 4'(cnt_n - 5'd1);

   // element pair touched by the rotation, y uses the negated sine
   always_comb begin
      case (axis_ff)
         AXIS_X:  begin pos_i = 2'd1; pos_j = 2'd2; end
         AXIS_Y:  begin pos_i = 2'd0; pos_j = 2'd2; end
         default: begin pos_i = 2'd0; pos_j = 2'd1; end
      endcase
      s_op  = (axis_ff == AXIS_Y) ? MB_NSIN : MB_SIN;
      ns_op = (axis_ff == AXIS_Y) ? MB_SIN : MB_NSIN;
   end

   assign col_off = 4'({sub_ff, 1'b0}) + 4'(sub_ff);
   assign addr_a  = base_ff + AW'(col_off + 4'(pos_i));
   assign addr_b  = base_ff + AW'(col_off + 4'(pos_j));
   assign row_off = 4'(sub_ff) + ((step_ff == 4'd1) ? 4'd3 : ((step_ff == 4'd2) ? 4'd6 : 4'd0));
   assign is_last = single_ff || (mat_ff == lastk_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         sub_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sub_ff       <= sub_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mat_ff    <= mat_in;
      lastk_ff  <= lastk_in;
      single_ff <= single_in;
      axis_ff   <= axis_in;
      base_ff   <= base_in;
      used_ff   <= used_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sub_in       = sub_ff;
      mat_in       = mat_ff;
      lastk_in     = lastk_ff;
      single_in    = single_ff;
      axis_in      = axis_ff;
      base_in      = base_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      used_in      = used_ff;
      last_in      = last_ff;
      cmd          = '0;
      mem_waddr    = clr_ff;
      mem_raddr    = '0;

      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = WS_ZERO;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               step_in = '0;
               sub_in  = '0;
               case (req_mode)
                  MODE_LOAD: begin
                     if (mi_ok && (req_elem_index < 4'(ELEMS))) begin
                        cmd.mem_we = 1'b1;
                        cmd.wsel   = WS_REQ;
                        mem_waddr  = mi_base + AW'(req_elem_index);
                     end
                  end
                  MODE_ROTATE: begin
                     if (mi_ok) begin
                        cmd.capture = 1'b1;
                        base_in     = mi_base;
                        axis_in     = req_axis;
                        state_in    = ST_TRIG;
                     end
                  end
                  MODE_POINT: begin
                     cmd.capture = 1'b1;
                     if (cfg.paired) begin
                        if (mi_ok) begin
                           base_in   = mi_base;
                           mat_in    = req_matrix_index;
                           single_in = 1'b1;
                           state_in  = ST_APPLY;
                        end
                     end else begin
                        base_in   = '0;
                        mat_in    = '0;
                        lastk_in  = cnt_last;
                        single_in = 1'b0;
                        state_in  = ST_APPLY;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_TRIG: begin
            // sub 0 sine, sub 1 cosine; horner steps alternate multiply and add
            cmd.trig_cos = sub_ff[0];
            step_in      = step_ff + 4'd1;
            case (step_ff)
               4'd0: cmd.arg_load = 1'b1;
               4'd1: begin
                  cmd.mul_a = MA_ARG;
                  cmd.mul_b = MB_ARG;
               end
               4'd2: begin
                  cmd.x2_load   = 1'b1;
                  cmd.poly_init = 1'b1;
               end
               4'd3, 4'd5, 4'd7, 4'd9: begin
                  cmd.mul_a = MA_POLY;
                  cmd.mul_b = MB_X2;
               end
               4'd4, 4'd6, 4'd8, 4'd10, 4'd12: begin
                  cmd.poly_step = 1'b1;
                  cmd.coef_idx  = 3'(step_ff[3:1] - 3'd2);
               end
               4'd11: begin
                  cmd.mul_a = MA_POLY;
                  cmd.mul_b = MB_ARG;
               end
               4'd13: begin
                  cmd.trig_load = 1'b1;
                  step_in       = '0;
                  if (sub_ff[0]) begin
                     sub_in   = '0;
                     state_in = ST_ROT;
                  end else begin
                     sub_in = 2'd1;
                  end
               end
               default: step_in = '0;
            endcase
         end

         ST_ROT: begin
            // one column per pass, sub is the column
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: mem_raddr = addr_a;
               4'd1: begin
                  mem_raddr   = addr_b;
                  cmd.ea_load = 1'b1;
               end
               4'd2: cmd.eb_load = 1'b1;
               4'd3: begin
                  cmd.mul_a = MA_EA;
                  cmd.mul_b = MB_COS;
               end
               4'd4: begin
                  cmd.acc_op = ACC_LOAD;
                  cmd.mul_a  = MA_EB;
                  cmd.mul_b  = s_op;
               end
               4'd5: cmd.acc_op = ACC_ADD;
               4'd6: begin
                  cmd.mem_we = 1'b1;
                  cmd.wsel   = WS_MIX;
                  mem_waddr  = addr_a;
                  cmd.mul_a  = MA_EA;
                  cmd.mul_b  = ns_op;
               end
               4'd7: begin
                  cmd.acc_op = ACC_LOAD;
                  cmd.mul_a  = MA_EB;
                  cmd.mul_b  = MB_COS;
               end
               4'd8: cmd.acc_op = ACC_ADD;
               4'd9: begin
                  cmd.mem_we = 1'b1;
                  cmd.wsel   = WS_MIX;
                  mem_waddr  = addr_b;
                  step_in    = '0;
                  if (sub_ff == 2'd2) begin
                     sub_in   = '0;
                     state_in = ST_IDLE;
                  end else begin
                     sub_in = sub_ff + 2'd1;
                  end
               end
               default: step_in = '0;
            endcase
         end

         ST_APPLY: begin
            // one output row per pass, sub is the row
            mem_raddr = base_ff + AW'(row_off);
            step_in   = step_ff + 4'd1;
            case (step_ff)
               4'd0: ;
               4'd1: begin
                  cmd.mul_a = MA_PX;
                  cmd.mul_b = MB_RDATA;
               end
               4'd2: begin
                  cmd.mul_a  = MA_PY;
                  cmd.mul_b  = MB_RDATA;
                  cmd.acc_op = ACC_LOAD;
               end
               4'd3: begin
                  cmd.mul_a  = MA_PZ;
                  cmd.mul_b  = MB_RDATA;
                  cmd.acc_op = ACC_ADD;
               end
               4'd4: cmd.acc_op = ACC_ADD;
               4'd5: begin
                  cmd.out_load = 1'b1;
                  cmd.out_row  = sub_ff;
                  step_in      = '0;
                  if (sub_ff == 2'd2) begin
                     sub_in       = '0;
                     rsp_valid_in = 1'b1;
                     used_in      = mat_ff;
                     last_in      = is_last;
                     if (is_last) begin
                        state_in = ST_IDLE;
                     end else begin
                        mat_in  = mat_ff + 4'd1;
                        base_in = base_ff + AW'(ELEMS);
                     end
                  end else begin
                     sub_in = sub_ff + 2'd1;
                  end
               end
               default: step_in = '0;
            endcase
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_used_matrix = used_ff;
   assign rsp_last_result = last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rotation_matrix_compose_apply_core.sv -----
// top level of the rotation matrix compose/apply block: config registers and wiring
// depends on rmca_pkg, rmca_ctrl and rmca_datapath
//
//   channel   ports                               handshake
//   -------   ---------------------------------   --------------------------------
//   item in   req_* fields                        taken when start and not busy
//   result    rsp_out_x/y/z, rsp_used_matrix,     rsp_valid strobe, one cycle,
//             rsp_last_result                     no back pressure
//   config    csr_we, csr_index, csr_wdata        written when csr_we is high
//
// after reset every word of the matrix store is cleared, with busy high
// a load is done in its accept cycle; a rotation runs two trig passes (sine, then
// cosine) through the shared multiplier, then three column updates
// a point runs three rows per matrix applied, each row in turn on the
// single store read port and multiplier, so its results are spaced apart
// busy drops in the cycle the last result shows; the receiver cannot stall
// reset is synchronous and active high
`default_nettype none

module rotation_matrix_compose_apply_core import rmca_pkg::*; #(
   parameter int NUM_MATRICES = 16,
   parameter int ANGLE_BITS   = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [3:0]         req_matrix_index,
   input  wire logic [3:0]         req_elem_index,
   input  wire logic signed [17:0] req_elem_value,
   input  wire logic [1:0]         req_axis,
   input  wire logic [15:0]        req_angle,
   input  wire logic signed [31:0] req_px,
   input  wire logic signed [31:0] req_py,
   input  wire logic signed [31:0] req_pz,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic [3:0]              rsp_used_matrix,
   output logic                    rsp_last_result,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [4:0]         csr_wdata
);

   localparam int AW = $clog2(NUM_MATRICES * ELEMS);

   cfg_type       cfg_ff;
   cmd_type       cmd;
   logic [AW-1:0] mem_waddr, mem_raddr;

   // config registers; write them only while idle, the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.paired <= 1'b0;
         cfg_ff.count  <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAIRED: cfg_ff.paired <= csr_wdata[0];
            CSR_COUNT:  cfg_ff.count  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // sequencing, address generation and result strobe
   rmca_ctrl #(
      .NUM_MATRICES(NUM_MATRICES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_mode        (req_mode),
      .req_matrix_index(req_matrix_index),
      .req_elem_index  (req_elem_index),
      .req_axis        (req_axis),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .mem_waddr       (mem_waddr),
      .mem_raddr       (mem_raddr),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_used_matrix (rsp_used_matrix),
      .rsp_last_result (rsp_last_result)
   );

   // store, multiplier, accumulator and rounding/saturation
   rmca_datapath #(
      .NUM_MATRICES(NUM_MATRICES),
      .ANGLE_BITS  (ANGLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .mem_waddr     (mem_waddr),
      .mem_raddr     (mem_raddr),
      .req_elem_value(req_elem_value),
      .req_angle     (req_angle),
      .req_px        (req_px),
      .req_py        (req_py),
      .req_pz        (req_pz),
      .out_x         (rsp_out_x),
      .out_y         (rsp_out_y),
      .out_z         (rsp_out_z)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/rmca_checker.sv -----
// port-level checks for the rotation matrix compose/apply block, bound to the top
// depends on rmca_pkg and rotation_matrix_compose_apply_core
`default_nettype none

module rmca_checker import rmca_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_mode,
   input wire logic       rsp_valid,
   input wire logic       rsp_last_result
);

   // store clearing keeps the block busy right after reset
   a_clear_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // results of one point are spaced apart
   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back results");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !busy)
      else $error("busy on last result");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("idle before last result");

   // a load finishes in its accept cycle and gives no result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_LOAD) |=> !rsp_valid && !busy)
      else $error("load item produced activity");

endmodule

bind rotation_matrix_compose_apply_core rmca_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_last_result(rsp_last_result)
);

`default_nettype wire
